>>> hw/rtl/qkd_pkg.sv
// Package for the quadrature knob and key decoder.
// Holds the payload and configuration types, the operation and register codes,
// and the quadrature transition table. No dependencies.
`default_nettype none

package qkd_pkg;

    // Operation codes of an input item.
    localparam logic OpSample = 1'b0;
    localparam logic OpPoll   = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CfgIndexW = 1;
    localparam logic [CfgIndexW-1:0] RegIdleTimeout    = 1'd0;
    localparam logic [CfgIndexW-1:0] RegStepsPerDetent = 1'd1;
    localparam int unsigned CfgDataW = 16;

    // Reset values of the configuration registers.
    localparam logic [15:0] IdleTimeoutReset    = 16'd200;
    localparam logic [2:0]  StepsPerDetentReset = 3'd2;

    typedef struct packed {
        logic        operation;
        logic        knob_a;
        logic        knob_b;
        logic [31:0] now_tick;
        logic        display_awake;
        logic        left_pin;
        logic        right_pin;
        logic        power_pin;
    } item_t;

    typedef struct packed {
        logic left_pressed;
        logic right_pressed;
        logic key_up;
        logic knob_down;
        logic key_ok;
    } result_t;

    typedef struct packed {
        logic [15:0] idle_timeout;
        logic [2:0]  steps_per_detent;
    } cfg_t;

    // Sub-step for each (previous AB, current AB) pair, indexed {prev, cur}.
    typedef logic signed [1:0] sub_step_t;
    localparam sub_step_t QuadTable [16] = '{
         2'sd0,  2'sd1, -2'sd1,  2'sd0,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
         2'sd0, -2'sd1,  2'sd1,  2'sd0
    };

endpackage

`default_nettype wire

>>> hw/rtl/qkd_item_if.sv
// Input item channel of the quadrature knob and key decoder.
// Depends on qkd_pkg for the item type.
`default_nettype none

interface qkd_item_if;
    logic          valid;
    logic          ready;
    qkd_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/qkd_result_if.sv
// Result item channel of the quadrature knob and key decoder.
// Depends on qkd_pkg for the result type.
`default_nettype none

interface qkd_result_if;
    logic             valid;
    logic             ready;
    qkd_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/qkd_cfg_if.sv
// Configuration write channel of the quadrature knob and key decoder.
// Depends on qkd_pkg for the index and data widths.
`default_nettype none

interface qkd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [qkd_pkg::CfgIndexW-1:0]     index;
    logic [qkd_pkg::CfgDataW-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/quadrature_knob_key_decoder.sv
// Quadrature knob and key decoder, top level.
// A poll is held in the input register, and its result is then loaded into the result register.
// Throughput: one item per cycle; a poll held in the input register waits only while the
// result register is full and not being read, and then stalls the input.
// Reset (rst_n, asynchronous, active low) clears the knob and key state and loads
// idle_timeout = 200 and steps_per_detent = 2; no clearing pass is needed.
`default_nettype none

module quadrature_knob_key_decoder (
    input  wire logic  clk,
    input  wire logic  rst_n,
    qkd_item_if.sink   item_in,
    qkd_result_if.source result_out,
    qkd_cfg_if.sink    cfg
);

    // Configuration registers. The user must write only while the block is idle;
    // the block itself does not enforce this, and the port is always ready.
    qkd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_timeout     <= qkd_pkg::IdleTimeoutReset;
            cfg_reg.steps_per_detent <= qkd_pkg::StepsPerDetentReset;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                qkd_pkg::RegIdleTimeout:
                begin
                    cfg_reg.idle_timeout <= cfg.data;
                end
                qkd_pkg::RegStepsPerDetent:
                begin
                    cfg_reg.steps_per_detent <= cfg.data[2:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // Input register. The held item is processed in the following cycle: a
    // sample always retires, a poll retires once the result register has
    // room. A new transfer is taken whenever the held item retires, so items
    // stream at one per cycle while results keep being taken.
    logic           in_valid_reg;
    qkd_pkg::item_t in_item_reg;
    logic           keys_can_accept;
    logic           in_retire;
    logic           is_poll;

    assign is_poll   = (in_item_reg.operation == qkd_pkg::OpPoll);
    assign in_retire = in_valid_reg && (!is_poll || keys_can_accept);
    assign item_in.ready = !in_valid_reg || in_retire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            in_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.ready && item_in.valid)
        begin
            in_item_reg <= item_in.data;
        end
    end

    // Knob path: samples update the sub-step accumulator and detent count.
    logic [7:0] detent_count;

    qkd_knob u_knob (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_en    (in_retire && !is_poll),
        .knob_a       (in_item_reg.knob_a),
        .knob_b       (in_item_reg.knob_b),
        .now_tick     (in_item_reg.now_tick),
        .cfg          (cfg_reg),
        .detent_count (detent_count)
    );

    // Key path: polls read the detent count left by all earlier samples and
    // load the result register.
    qkd_keys u_keys (
        .clk           (clk),
        .rst_n         (rst_n),
        .poll_en       (in_retire && is_poll),
        .detent_count  (detent_count),
        .display_awake (in_item_reg.display_awake),
        .left_pin      (in_item_reg.left_pin),
        .right_pin     (in_item_reg.right_pin),
        .power_pin     (in_item_reg.power_pin),
        .can_accept    (keys_can_accept),
        .result_valid  (result_out.valid),
        .result_ready  (result_out.ready),
        .result        (result_out.data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/qkd_knob.sv
// Knob accumulator: turns quadrature pin samples into a wrapping detent count.
// Depends on qkd_pkg for the transition table and configuration type.
`default_nettype none

module qkd_knob (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          sample_en,
    input  wire logic          knob_a,
    input  wire logic          knob_b,
    input  wire logic [31:0]   now_tick,
    input  wire qkd_pkg::cfg_t cfg,
    output logic [7:0]         detent_count
);

    logic [1:0]        prev_ab_reg;
    logic [1:0]        prev_ab_next;
    logic signed [3:0] sum_reg;
    logic signed [3:0] sum_next;
    logic [7:0]        detent_reg;
    logic [7:0]        detent_next;
    logic [31:0]       last_move_reg;
    logic [31:0]       last_move_next;

    logic [1:0]           cur_ab;
    qkd_pkg::sub_step_t   delta;
    logic [31:0]          elapsed;
    logic signed [4:0]    base;
    logic signed [4:0]    acc;
    logic signed [4:0]    limit;

    always_comb
    begin
        cur_ab         = {knob_a, knob_b};
        delta          = qkd_pkg::QuadTable[{prev_ab_reg, cur_ab}];
        elapsed        = now_tick - last_move_reg;
        // Partial sub-steps are dropped after a long enough pause.
        base           = (elapsed > {16'd0, cfg.idle_timeout}) ? 5'sd0
                                                               : 5'(sum_reg);
        acc            = base + 5'(delta);
        limit          = $signed({2'b00, cfg.steps_per_detent});
        prev_ab_next   = prev_ab_reg;
        sum_next       = sum_reg;
        detent_next    = detent_reg;
        last_move_next = last_move_reg;
        if (sample_en)
        begin
            prev_ab_next = cur_ab;
            if (delta != 2'sd0)
            begin
                last_move_next = now_tick;
                if (acc >= limit)
                begin
                    detent_next = detent_reg + 8'd1;
                    sum_next    = 4'sd0;
                end
                else if (acc <= -limit)
                begin
                    detent_next = detent_reg - 8'd1;
                    sum_next    = 4'sd0;
                end
                else
                begin
                    sum_next = acc[3:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ab_reg   <= 2'd0;
            sum_reg       <= 4'sd0;
            detent_reg    <= 8'd0;
            last_move_reg <= 32'd0;
        end
        else
        begin
            prev_ab_reg   <= prev_ab_next;
            sum_reg       <= sum_next;
            detent_reg    <= detent_next;
            last_move_reg <= last_move_next;
        end
    end

    assign detent_count = detent_reg;

endmodule

`default_nettype wire

>>> hw/rtl/qkd_keys.sv
// Key reporter: answers polls with button levels and one-poll knob presses,
// and holds the result register. Depends on qkd_pkg for the result type.
`default_nettype none

module qkd_keys (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             poll_en,
    input  wire logic [7:0]       detent_count,
    input  wire logic             display_awake,
    input  wire logic             left_pin,
    input  wire logic             right_pin,
    input  wire logic             power_pin,
    output logic                  can_accept,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output qkd_pkg::result_t      result
);

    logic             press_held_reg;
    logic             press_held_next;
    logic [7:0]       reported_reg;
    logic [7:0]       reported_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    qkd_pkg::result_t out_data_reg;
    qkd_pkg::result_t out_data_next;

    logic [7:0] diff;

    always_comb
    begin
        diff            = detent_count - reported_reg;
        press_held_next = press_held_reg;
        reported_next   = reported_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_data_next   = out_data_reg;
        if (poll_en)
        begin
            out_valid_next              = 1'b1;
            out_data_next.left_pressed  = ~left_pin;
            out_data_next.right_pressed = ~right_pin;
            out_data_next.key_ok        = ~power_pin;
            out_data_next.key_up        = 1'b0;
            out_data_next.knob_down     = 1'b0;
            if (press_held_reg)
            begin
                press_held_next = 1'b0;
            end
            else if (diff != 8'd0)
            begin
                reported_next = detent_count;
                if (display_awake)
                begin
                    // The sign of the modular difference gives the direction.
                    out_data_next.knob_down = ~diff[7];
                    out_data_next.key_up    = diff[7];
                    press_held_next         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_held_reg <= 1'b0;
            reported_reg   <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            press_held_reg <= press_held_next;
            reported_reg   <= reported_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign can_accept   = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

`default_nettype wire
